// File: rtl/lru_dictionary_lzw_decoder_core_macros.svh
// assertion helpers shared by the checker
`ifndef LRU_DICTIONARY_LZW_DECODER_CORE_MACROS_SVH
`define LRU_DICTIONARY_LZW_DECODER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define LZWD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked on every clock edge, reset included
`define LZWD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/lzwd_pkg.sv
package lzwd_pkg;
    localparam int unsigned SYM_W      = 9;
    localparam int unsigned CODE_W     = 12;
    localparam int unsigned ROOT_MAX   = 257;
    localparam int unsigned FIRST_NODE = 258;
    localparam int unsigned FILL_SYM   = 65;
    localparam int unsigned MAX_OUT    = 64;
    localparam int unsigned OCNT_W     = 7;
endpackage

// File: rtl/lru_dictionary_lzw_decoder_core.sv
// LZW decoder with a least-recently-used tree dictionary. Each accepted code
// is turned into its string, one 9-bit symbol per output transfer, root first,
// with last marking the final symbol (at most 64 symbols per code). Codes are
// queued in a two-entry front queue; the back engine walks the chain up node
// by node, then down, bound by the single read port of each dictionary memory.
// After reset the engine clears every dictionary entry before it takes its
// first code.
module lru_dictionary_lzw_decoder_core
    import lzwd_pkg::*;
#(
    parameter int unsigned TREE_SIZE = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CODE_W-1:0] s_code,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SYM_W-1:0]  m_symbol,
    output logic              m_last
);
    localparam int unsigned AW = $clog2(TREE_SIZE);

    // queue between front and back
    logic          q_valid;
    logic          q_ready;
    logic [AW-1:0] q_code;

    lzwd_front #(.AW(AW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_code(s_code),
        .q_valid(q_valid), .q_ready(q_ready), .q_code(q_code));

    lzwd_back #(.TREE_SIZE(TREE_SIZE), .AW(AW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_code(q_code),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_symbol(m_symbol), .m_last(m_last));
endmodule

// File: rtl/lzwd_ram.sv
module lzwd_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/lzwd_front.sv
module lzwd_front
    import lzwd_pkg::*;
#(
    parameter int unsigned AW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [CODE_W-1:0] s_code,
    output logic          q_valid,
    input  logic          q_ready,
    output logic [AW-1:0] q_code
);
    // two entry queue of codes wrapped to the tree size
    logic [AW-1:0] slot_reg [2];
    logic [1:0]    cnt_reg;
    logic          rd_reg;
    logic          wr_reg;
    logic [AW-1:0] wrapped;
    logic          push;
    logic          pop;

    // low address bits of the zero-extended code
    assign wrapped = AW'({{AW{1'b0}}, s_code});

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_code  = slot_reg[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= wrapped;
        end
    end
endmodule

// File: rtl/lzwd_back.sv
module lzwd_back
    import lzwd_pkg::*;
#(
    parameter int unsigned TREE_SIZE = 4096,
    parameter int unsigned AW        = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  logic [AW-1:0]    q_code,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [SYM_W-1:0] m_symbol,
    output logic             m_last
);
    typedef enum logic [16:0] {
        S_INIT  = 17'b00000000000000001,
        S_IDLE  = 17'b00000000000000010,
        S_Y     = 17'b00000000000000100,
        S_Q     = 17'b00000000000001000,
        S_UCHK  = 17'b00000000000010000,
        S_URD   = 17'b00000000000100000,
        S_UWR1  = 17'b00000000001000000,
        S_UWR2  = 17'b00000000010000000,
        S_UWR3  = 17'b00000000100000000,
        S_TOP0  = 17'b00000001000000000,
        S_TOP1  = 17'b00000010000000000,
        S_TOP2  = 17'b00000100000000000,
        S_DRD   = 17'b00001000000000000,
        S_DWR   = 17'b00010000000000000,
        S_FIN   = 17'b00100000000000000,
        S_WAIT  = 17'b01000000000000000,
        S_URD2  = 17'b10000000000000000
    } state_t;

    localparam int unsigned SW = AW + 1;
    localparam logic [AW-1:0] LAST_NODE = AW'(TREE_SIZE - 1);

    state_t state_reg, state_next;
    logic [AW-1:0] d_reg, y_reg, h_reg, p_reg, pend_reg, ptr_reg;
    logic [AW-1:0] nx_reg;
    logic [SW-1:0] steps_reg, k_reg;
    logic [OCNT_W-1:0] cnt_reg;
    logic [SYM_W-1:0] sym_reg;
    logic          last_reg;
    logic          ov_reg;

    // memory ports
    logic          par_we, ext_we, prv_we, nxt_we;
    logic [AW-1:0] par_wa, ext_wa, prv_wa, nxt_wa;
    logic [AW-1:0] par_wd, prv_wd, nxt_wd;
    logic [SYM_W-1:0] ext_wd;
    logic [AW-1:0] par_ra, ext_ra, prv_ra, nxt_ra;
    logic [AW-1:0] par_rd, prv_rd, nxt_rd;
    logic [SYM_W-1:0] ext_rd;

    lzwd_ram #(.WIDTH(AW), .DEPTH(TREE_SIZE)) u_par (
        .aclk(aclk), .we(par_we), .waddr(par_wa), .wdata(par_wd),
        .raddr(par_ra), .rdata(par_rd));
    lzwd_ram #(.WIDTH(SYM_W), .DEPTH(TREE_SIZE)) u_ext (
        .aclk(aclk), .we(ext_we), .waddr(ext_wa), .wdata(ext_wd),
        .raddr(ext_ra), .rdata(ext_rd));
    lzwd_ram #(.WIDTH(AW), .DEPTH(TREE_SIZE)) u_prv (
        .aclk(aclk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
        .raddr(prv_ra), .rdata(prv_rd));
    lzwd_ram #(.WIDTH(AW), .DEPTH(TREE_SIZE)) u_nxt (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
        .raddr(nxt_ra), .rdata(nxt_rd));

    logic out_free;
    assign out_free = !m_valid || m_ready;
    assign m_valid  = ov_reg;
    assign m_symbol = sym_reg;
    assign m_last   = last_reg;
    assign q_ready  = (state_reg == S_IDLE);

    logic is_root;
    assign is_root = (d_reg <= AW'(ROOT_MAX));

    // a new symbol goes into the output register
    logic beat_load;
    assign beat_load = out_free && ((state_reg == S_TOP2) ||
                       (state_reg == S_DWR && cnt_reg < OCNT_W'(MAX_OUT)));

    // single combined block: memory controls and state
    always_comb begin
        state_next = state_reg;
        par_we = 1'b0; ext_we = 1'b0; prv_we = 1'b0; nxt_we = 1'b0;
        par_wa = '0; ext_wa = '0; prv_wa = '0; nxt_wa = '0;
        par_wd = '0; ext_wd = '0; prv_wd = '0; nxt_wd = '0;
        par_ra = d_reg; ext_ra = p_reg; prv_ra = d_reg; nxt_ra = d_reg;
        unique case (state_reg)
            S_INIT: begin
                // sweep one entry per cycle into its reset value
                par_we = 1'b1; ext_we = 1'b1; prv_we = 1'b1; nxt_we = 1'b1;
                par_wa = ptr_reg; ext_wa = ptr_reg; prv_wa = ptr_reg; nxt_wa = ptr_reg;
                if (ptr_reg >= AW'(FIRST_NODE)) begin
                    par_wd = (ptr_reg == AW'(FIRST_NODE)) ? AW'(FILL_SYM) : ptr_reg - 1'b1;
                    ext_wd = SYM_W'(FILL_SYM);
                    prv_wd = (ptr_reg == AW'(FIRST_NODE)) ? '0 : ptr_reg - 1'b1;
                    nxt_wd = (ptr_reg == LAST_NODE) ? '0 : ptr_reg + 1'b1;
                end else if (ptr_reg == '0) begin
                    prv_wd = LAST_NODE;
                    nxt_wd = AW'(FIRST_NODE);
                end
                if (ptr_reg == LAST_NODE) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                prv_ra = '0;
                if (q_valid) begin
                    state_next = S_Y;
                end
            end
            S_Y: begin
                // prv_rd = y
                prv_ra = prv_rd;
                state_next = S_Q;
            end
            S_Q: begin
                // prv_rd = q = prev[y]
                prv_we = 1'b1; prv_wa = '0; prv_wd = prv_rd;
                nxt_we = 1'b1; nxt_wa = prv_rd; nxt_wd = '0;
                state_next = S_UCHK;
            end
            S_UCHK: begin
                if (!is_root && steps_reg < SW'(TREE_SIZE)) begin
                    state_next = S_URD;
                end else begin
                    nxt_ra = '0;
                    state_next = S_TOP0;
                end
            end
            S_URD: begin
                state_next = S_URD2;
            end
            S_URD2: begin
                // nx/parent captured; unlink d
                nxt_we = 1'b1; nxt_wa = prv_rd; nxt_wd = nxt_rd;
                prv_we = 1'b1; prv_wa = nxt_rd; prv_wd = prv_rd;
                par_we = 1'b1; par_wa = d_reg; par_wd = p_reg;
                state_next = S_UWR1;
            end
            S_UWR1: begin
                nxt_we = 1'b1; nxt_wa = d_reg; nxt_wd = h_reg;
                prv_we = 1'b1; prv_wa = h_reg; prv_wd = d_reg;
                state_next = S_UWR2;
            end
            S_UWR2: begin
                state_next = S_UCHK;
            end
            S_TOP0: begin
                nxt_ra = '0;
                state_next = S_TOP1;
            end
            S_TOP1: begin
                // nxt_rd = next[0]
                nxt_we = 1'b1; nxt_wa = y_reg; nxt_wd = nxt_rd;
                prv_we = 1'b1; prv_wa = nxt_rd; prv_wd = y_reg;
                ext_we = 1'b1; ext_wa = pend_reg; ext_wd = d_reg[SYM_W-1:0];
                state_next = S_TOP2;
            end
            S_TOP2: begin
                nxt_we = 1'b1; nxt_wa = '0; nxt_wd = h_reg;
                prv_we = 1'b1; prv_wa = h_reg; prv_wd = '0;
                if (out_free) begin
                    state_next = S_DRD;
                end
            end
            S_DRD: begin
                par_ra = p_reg; ext_ra = p_reg;
                if (k_reg < steps_reg && p_reg != '0) begin
                    state_next = S_UWR3;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_UWR3: begin
                state_next = S_DWR;
            end
            S_DWR: begin
                if (out_free || cnt_reg >= OCNT_W'(MAX_OUT)) begin
                    par_we = 1'b1; par_wa = p_reg; par_wd = d_reg;
                    state_next = S_DRD;
                end
            end
            S_FIN: begin
                par_we = 1'b1; par_wa = y_reg; par_wd = d_reg;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            ptr_reg   <= '0;
            pend_reg  <= '0;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (beat_load) begin
                ov_reg <= 1'b1;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT: ptr_reg <= ptr_reg + 1'b1;
                S_IDLE: begin
                    if (q_valid) begin
                        d_reg     <= q_code;
                        p_reg     <= '0;
                        steps_reg <= '0;
                        k_reg     <= '0;
                        cnt_reg   <= '0;
                    end
                end
                S_Y: begin
                    y_reg <= prv_rd;
                    h_reg <= prv_rd;
                end
                S_URD2: begin
                    nx_reg <= nxt_rd;
                end
                S_UWR1: begin
                    h_reg     <= d_reg;
                    p_reg     <= d_reg;
                    d_reg     <= par_rd;
                    steps_reg <= steps_reg + 1'b1;
                end
                S_TOP2: begin
                    if (out_free) begin
                        pend_reg <= y_reg;
                        sym_reg  <= d_reg[SYM_W-1:0];
                        cnt_reg  <= OCNT_W'(1);
                        // root alone when nothing was walked
                        last_reg <= (steps_reg == '0) || (p_reg == '0);
                    end
                end
                S_UWR3: begin
                    nx_reg <= par_rd;
                end
                S_DWR: begin
                    if (out_free || cnt_reg >= OCNT_W'(MAX_OUT)) begin
                        if (cnt_reg < OCNT_W'(MAX_OUT)) begin
                            sym_reg  <= ext_rd;
                            cnt_reg  <= cnt_reg + 1'b1;
                            // final step of the walk down, or the cut at max symbols
                            last_reg <= (cnt_reg + 1'b1 == OCNT_W'(MAX_OUT)) ||
                                        (k_reg + 1'b1 >= steps_reg) || (nx_reg == '0);
                        end
                        d_reg <= p_reg;
                        p_reg <= nx_reg;
                        k_reg <= k_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: rtl/lzwd_checker.sv
`include "lru_dictionary_lzw_decoder_core_macros.svh"
module lzwd_checker
    import lzwd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [SYM_W-1:0] m_symbol,
    input logic             m_last
);
    `LZWD_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_symbol) && $stable(m_last), "result dropped")
    `LZWD_ASSERT(a_in_hold, s_valid && !s_ready |=> s_valid, "input valid dropped")
    `LZWD_ASSERT_ALWAYS(a_rst, !aresetn |=> !m_valid, "valid after reset")
endmodule

bind lru_dictionary_lzw_decoder_core lzwd_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_symbol(m_symbol), .m_last(m_last));

// File: tb/sv/lru_dictionary_lzw_decoder_core_tb.sv
module lru_dictionary_lzw_decoder_core_tb;
    import lzwd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TREE_N = 4096;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } sym_beat_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [CODE_W-1:0] s_code;
    logic              m_valid;
    logic              m_ready;
    logic [SYM_W-1:0]  m_symbol;
    logic              m_last;

    lru_dictionary_lzw_decoder_core #(.TREE_SIZE(TREE_N)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_code  (s_code),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_symbol(m_symbol),
        .m_last  (m_last)
    );

    // shadow dictionary kept by the testbench
    logic [CODE_W-1:0] tree_parent [TREE_N];
    logic [SYM_W-1:0]  tree_ext    [TREE_N];
    logic [CODE_W-1:0] age_prev    [TREE_N];
    logic [CODE_W-1:0] age_next    [TREE_N];
    logic [CODE_W-1:0] open_node;

    sym_beat_t         symbols_due[$];
    logic [CODE_W-1:0] fresh_nodes[$];   // most recently created entries

    int  errors;
    int  codes_sent;
    int  symbols_seen;
    int  burst_left;
    int  hold_cycles;       // receiver hold-off, counted down by the receiver
    int  rx_cycle;
    bit  hold_req;          // asks the receiver for one long hold-off
    bit  hold_taken;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #1000ms;
        $display("timeout at %0t", $time);
        $display("lru_dictionary_lzw_decoder_core_tb: done, errors");
        $finish;
    end

    // dictionary state right after reset
    task automatic dict_reset();
        for (int n = 0; n < TREE_N; n++) begin
            tree_parent[n] = '0;
            tree_ext[n]    = '0;
            age_prev[n]    = '0;
            age_next[n]    = '0;
        end
        for (int n = FIRST_NODE; n < TREE_N; n++) begin
            tree_parent[n] = (n == FIRST_NODE) ? CODE_W'(FILL_SYM) : CODE_W'(n - 1);
            tree_ext[n]    = SYM_W'(FILL_SYM);
        end
        for (int n = FIRST_NODE; n + 1 < TREE_N; n++) begin
            age_prev[n + 1] = CODE_W'(n);
            age_next[n]     = CODE_W'(n + 1);
        end
        age_prev[0]          = CODE_W'(TREE_N - 1);
        age_next[0]          = CODE_W'(FIRST_NODE);
        age_prev[FIRST_NODE] = '0;
        age_next[TREE_N - 1] = '0;
        open_node            = '0;
    endtask

    // decode one code on the shadow dictionary and queue its symbols
    task automatic decode_code(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] cur, victim, nb, pb, head, back, tmp;
        int unsigned       steps;
        sym_beat_t         str[$];
        sym_beat_t         beat;
        cur    = code;
        steps  = 0;
        // least recently used entry becomes the new node
        victim = age_prev[0];
        nb     = age_prev[victim];
        age_prev[0]  = nb;
        age_next[nb] = '0;
        head = victim;
        back = '0;
        // climb: move each node to the recent end, reverse the parent link
        while (cur > ROOT_MAX && steps < TREE_N) begin
            nb = age_next[cur];
            pb = age_prev[cur];
            age_next[pb]   = nb;
            age_prev[nb]   = pb;
            age_next[cur]  = head;
            age_prev[head] = cur;
            head = cur;
            tmp  = tree_parent[cur];
            tree_parent[cur] = back;
            back = cur;
            cur  = tmp;
            steps++;
        end
        nb = age_next[0];
        age_next[victim] = nb;
        age_prev[nb]     = victim;
        age_next[0]      = head;
        age_prev[head]   = '0;

        tree_ext[open_node] = cur[SYM_W-1:0];
        beat.symbol = cur[SYM_W-1:0];
        beat.last   = 1'b0;
        str.push_back(beat);
        open_node = victim;
        // descend: emit extensions and restore links
        for (int unsigned k = 0; k < steps && back != 0; k++) begin
            tmp = tree_parent[back];
            if (str.size() < MAX_OUT) begin
                beat.symbol = tree_ext[back];
                str.push_back(beat);
            end
            tree_parent[back] = cur;
            cur  = back;
            back = tmp;
        end
        tree_parent[victim] = cur;
        str[str.size() - 1].last = 1'b1;
        foreach (str[i]) symbols_due.push_back(str[i]);
        fresh_nodes.push_back(victim);
        if (fresh_nodes.size() > 8) void'(fresh_nodes.pop_front());
    endtask

    // offer one code, wait for its transfer, then insert a gap between bursts
    task automatic send_code(input logic [CODE_W-1:0] code, input bit no_gap = 0);
        int gap;
        s_valid <= 1'b1;
        s_code  <= code;
        do @(posedge aclk); while (!s_ready);
        decode_code(code);
        codes_sent++;
        if (!no_gap) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 8);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
                // some bursts are long stretches with no gaps at all
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 10);
            end
        end
    endtask

    // receiver: stall pattern plus long hold-offs, and the result check
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            rx_cycle    <= 0;
            hold_cycles <= 0;
            hold_taken  <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (m_valid && m_ready) begin
                symbols_seen++;
                if (symbols_due.size() == 0) begin
                    $display("%0t: unexpected symbol %0d last %0b", $time, m_symbol, m_last);
                    errors++;
                end else begin
                    sym_beat_t want;
                    want = symbols_due.pop_front();
                    if (m_symbol !== want.symbol) begin
                        $display("%0t: symbol expected %0d actual %0d",
                                 $time, want.symbol, m_symbol);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, m_last);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_taken) begin
                hold_taken  <= 1'b1;
                hold_cycles <= 1500;
                m_ready     <= 1'b0;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                // alternate windows: always ready, light stalls, heavy stalls
                case ((rx_cycle / 300) % 3)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    task automatic test_roots();
        send_code(CODE_W'(0));
        send_code(CODE_W'(ROOT_MAX));
        send_code(CODE_W'(FILL_SYM));
        send_code(CODE_W'(1));
        send_code(CODE_W'(256));
    endtask

    // codes that reuse the entries just created
    task automatic test_new_nodes();
        for (int i = 0; i < 8; i++) send_code(fresh_nodes[fresh_nodes.size() - 1]);
        send_code(fresh_nodes[0]);
        send_code(CODE_W'($urandom_range(0, ROOT_MAX)));
        send_code(fresh_nodes[fresh_nodes.size() - 1]);
    endtask

    // long reset chains: strings cut at 64 symbols, top code and first node
    task automatic test_long_chain();
        send_code(CODE_W'(TREE_N - 1));
        send_code(CODE_W'(FIRST_NODE));
        send_code(CODE_W'(1000));
        send_code(CODE_W'(FIRST_NODE + 1));
        send_code(CODE_W'(2730));
        send_code(CODE_W'(1365));
    endtask

    // receiver holds off while codes keep coming, so the input stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) begin
            if (i % 3 == 0) send_code(CODE_W'($urandom_range(0, ROOT_MAX)), 1);
            else send_code(fresh_nodes[$urandom_range(0, fresh_nodes.size() - 1)], 1);
        end
    endtask

    task automatic test_random(input int count);
        int pick;
        logic [CODE_W-1:0] c;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)      c = fresh_nodes[$urandom_range(0, fresh_nodes.size() - 1)];
            else if (pick < 93) c = CODE_W'($urandom_range(0, ROOT_MAX));
            else if (pick < 96) c = CODE_W'($urandom_range(FIRST_NODE, TREE_N - 1));
            else if (pick < 98) c = CODE_W'($urandom);
            else                c = fresh_nodes[0];
            send_code(c);
        end
    endtask

    initial begin
        int waited;
        errors       = 0;
        codes_sent   = 0;
        symbols_seen = 0;
        burst_left   = 0;
        hold_req     = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_code       = '0;
        dict_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_roots();
        test_new_nodes();
        test_long_chain();
        test_backpressure();
        test_random(470);
        s_valid <= 1'b0;

        waited = 0;
        while (symbols_due.size() != 0 && waited < 2000000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (200) @(posedge aclk);
        if (symbols_due.size() != 0) begin
            $display("%0t: %0d symbols never arrived", $time, symbols_due.size());
            errors++;
        end
        $display("sent %0d codes (roots, fresh entries, long chains), checked %0d symbols",
                 codes_sent, symbols_seen);
        $display("with bursty input, patterned output stalls and one long hold-off");
        if (errors == 0) begin
            $display("lru_dictionary_lzw_decoder_core_tb: done, clean");
        end else begin
            $display("lru_dictionary_lzw_decoder_core_tb: done, errors");
        end
        $finish;
    end
endmodule
